// ----- design/pcw_pkg.sv -----
// shared types, constants and helpers for the periodic cell wrap unit
package pcw_pkg;

   localparam int POS_FRAC_BITS = 16;
   localparam int LAT_FRAC_BITS = 12;
   localparam int FRAC_BITS     = 32;
   localparam int TOL_BITS      = 12;
   localparam int LAT_W         = 20;
   localparam int POS_W         = 32;
   localparam int LAT_REG_W     = 3 * LAT_W;
   localparam int WSHIFT        = FRAC_BITS + LAT_FRAC_BITS - POS_FRAC_BITS;

   localparam int CROSS_W    = 2 * LAT_W + 1;
   localparam int DETP_W     = LAT_W + CROSS_W;
   localparam int DET_W      = DETP_W + 2;
   localparam int PH_W       = POS_W / 2;
   localparam int PL_W       = POS_W - PH_W;
   localparam int NPH_W      = CROSS_W + PH_W;
   localparam int NPL_W      = CROSS_W + PL_W + 1;
   localparam int NUM_W      = CROSS_W + POS_W + 2;
   localparam int DVD_RAW_W  = NUM_W + WSHIFT;
   localparam int DSTEP      = 3;
   localparam int DIV_STAGES = (DVD_RAW_W + DSTEP - 1) / DSTEP;
   localparam int DVD_W      = DIV_STAGES * DSTEP;
   localparam int REM_W      = DET_W;
   localparam int G_W        = FRAC_BITS + 1;
   localparam int OP_W       = LAT_W + G_W;
   localparam int SUM_W      = OP_W + 3;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 64;

   localparam logic [LAT_REG_W-1:0] LAT_ONE = LAT_REG_W'(1) << LAT_FRAC_BITS;
   localparam logic [TOL_BITS-1:0]  TOL_RESET = TOL_BITS'(4);

   typedef enum logic [1:0] {
      REG_LAT_A,
      REG_LAT_B,
      REG_LAT_C,
      REG_TOL
   } reg_index_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } req_word_type;

   typedef struct packed {
      logic signed [POS_W-1:0] wrapped_x;
      logic signed [POS_W-1:0] wrapped_y;
      logic signed [POS_W-1:0] wrapped_z;
      logic                    singular_lattice;
   } rsp_word_type;

   function automatic logic signed [LAT_W-1:0] lat_field(input logic [LAT_REG_W-1:0] r,
                                                         input int k);
      return signed'(r[k*LAT_W +: LAT_W]);
   endfunction

endpackage

// ----- design/periodic_cell_wrap_unit.sv -----
// periodic cell wrap: fractional wrap of a position into the lattice unit cell
// pipeline: 43 register stages, 3 + (DIV_STAGES + 1) + 4
// throughput: one word per cycle; the whole pipeline advances together and
//   holds while an unaccepted rsp word waits
// the long division runs 3 quotient bits per stage over 35 stages
// reset: synchronous, clears valid bits and loads the unit lattice, tolerance 4
module periodic_cell_wrap_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pcw_pkg::req_word_type         req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pcw_pkg::rsp_word_type         rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pcw_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [pcw_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [pcw_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   localparam int LW  = pcw_pkg::LAT_W;
   localparam int CW  = pcw_pkg::CROSS_W;
   localparam int DS  = pcw_pkg::DIV_STAGES;
   localparam int FB  = pcw_pkg::FRAC_BITS;
   localparam int RW  = pcw_pkg::REM_W;
   localparam int DW  = pcw_pkg::DVD_W;
   localparam int GW  = pcw_pkg::G_W;
   localparam int SW  = pcw_pkg::SUM_W;
   localparam int PW  = pcw_pkg::POS_W;

   // configuration registers
   logic [pcw_pkg::LAT_REG_W-1:0] lat_ff [3];
   logic [pcw_pkg::TOL_BITS-1:0]  tol_ff;
   pcw_pkg::reg_index_type        csr_idx;
   logic                          csr_wr;

   assign csr_idx    = pcw_pkg::reg_index_type'(csr_paddr[4:3]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff[0] <= pcw_pkg::LAT_ONE;
         lat_ff[1] <= pcw_pkg::LAT_ONE << LW;
         lat_ff[2] <= pcw_pkg::LAT_ONE << (2 * LW);
         tol_ff    <= pcw_pkg::TOL_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            pcw_pkg::REG_LAT_A: lat_ff[0] <= csr_pwdata[pcw_pkg::LAT_REG_W-1:0];
            pcw_pkg::REG_LAT_B: lat_ff[1] <= csr_pwdata[pcw_pkg::LAT_REG_W-1:0];
            pcw_pkg::REG_LAT_C: lat_ff[2] <= csr_pwdata[pcw_pkg::LAT_REG_W-1:0];
            pcw_pkg::REG_TOL:   tol_ff    <= csr_pwdata[pcw_pkg::TOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         pcw_pkg::REG_LAT_A: csr_prdata = pcw_pkg::CSR_DW'(lat_ff[0]);
         pcw_pkg::REG_LAT_B: csr_prdata = pcw_pkg::CSR_DW'(lat_ff[1]);
         pcw_pkg::REG_LAT_C: csr_prdata = pcw_pkg::CSR_DW'(lat_ff[2]);
         pcw_pkg::REG_TOL:   csr_prdata = pcw_pkg::CSR_DW'(tol_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // lattice components, v[i][k] is component k of vector i
   logic signed [LW-1:0] v [3][3];
   always_comb begin
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            v[i][k] = pcw_pkg::lat_field(lat_ff[i], k);
   end

   logic adv;
   logic rsp_valid_ff;
   pcw_pkg::rsp_word_type rsp_data_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // stage 1: adjugate rows
   logic                  st1_vld_ff;
   pcw_pkg::req_word_type st1_pos_ff;
   logic signed [CW-1:0]  st1_c_ff [3][3];
   logic signed [CW-1:0]  st1_c_in [3][3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            logic signed [2*LW-1:0] pa;
            logic signed [2*LW-1:0] pb;
            pa = v[(j+1)%3][(k+1)%3] * v[(j+2)%3][(k+2)%3];
            pb = v[(j+1)%3][(k+2)%3] * v[(j+2)%3][(k+1)%3];
            st1_c_in[j][k] = CW'(pa) - CW'(pb);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) st1_vld_ff <= 1'b0;
      else if (adv) st1_vld_ff <= req_valid;
      if (adv) begin
         st1_pos_ff <= req_data;
         st1_c_ff   <= st1_c_in;
      end
   end

   // stage 2: partial products
   logic signed [PW-1:0] st1_p [3];
   assign st1_p[0] = st1_pos_ff.pos_x;
   assign st1_p[1] = st1_pos_ff.pos_y;
   assign st1_p[2] = st1_pos_ff.pos_z;

   logic                             st2_vld_ff;
   pcw_pkg::req_word_type            st2_pos_ff;
   logic signed [pcw_pkg::DETP_W-1:0] st2_detp_ff [3];
   logic signed [pcw_pkg::NPH_W-1:0]  st2_nph_ff [3][3];
   logic signed [pcw_pkg::NPL_W-1:0]  st2_npl_ff [3][3];
   logic signed [pcw_pkg::DETP_W-1:0] st2_detp_in [3];
   logic signed [pcw_pkg::NPH_W-1:0]  st2_nph_in [3][3];
   logic signed [pcw_pkg::NPL_W-1:0]  st2_npl_in [3][3];

   always_comb begin
      for (int k = 0; k < 3; k++)
         st2_detp_in[k] = v[0][k] * st1_c_ff[0][k];
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            st2_nph_in[j][k] = st1_c_ff[j][k] *
                               signed'(st1_p[k][PW-1:pcw_pkg::PL_W]);
            st2_npl_in[j][k] = st1_c_ff[j][k] *
                               signed'({1'b0, st1_p[k][pcw_pkg::PL_W-1:0]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) st2_vld_ff <= 1'b0;
      else if (adv) st2_vld_ff <= st1_vld_ff;
      if (adv) begin
         st2_pos_ff  <= st1_pos_ff;
         st2_detp_ff <= st2_detp_in;
         st2_nph_ff  <= st2_nph_in;
         st2_npl_ff  <= st2_npl_in;
      end
   end

   // stage 3: determinant and numerators
   logic                             st3_vld_ff;
   pcw_pkg::req_word_type            st3_pos_ff;
   logic signed [pcw_pkg::DET_W-1:0] st3_det_ff;
   logic signed [pcw_pkg::NUM_W-1:0] st3_num_ff [3];
   logic signed [pcw_pkg::DET_W-1:0] st3_det_in;
   logic signed [pcw_pkg::NUM_W-1:0] st3_num_in [3];

   always_comb begin
      st3_det_in = pcw_pkg::DET_W'(st2_detp_ff[0]) + pcw_pkg::DET_W'(st2_detp_ff[1])
                 + pcw_pkg::DET_W'(st2_detp_ff[2]);
      for (int j = 0; j < 3; j++) begin
         st3_num_in[j] = '0;
         for (int k = 0; k < 3; k++)
            st3_num_in[j] = st3_num_in[j]
                          + (pcw_pkg::NUM_W'(st2_nph_ff[j][k]) <<< pcw_pkg::PL_W)
                          + pcw_pkg::NUM_W'(st2_npl_ff[j][k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) st3_vld_ff <= 1'b0;
      else if (adv) st3_vld_ff <= st2_vld_ff;
      if (adv) begin
         st3_pos_ff <= st2_pos_ff;
         st3_det_ff <= st3_det_in;
         st3_num_ff <= st3_num_in;
      end
   end

   // divider pipeline, stage 0 loads magnitudes
   logic                  div_vld_ff  [DS+1];
   logic                  div_sing_ff [DS+1];
   pcw_pkg::req_word_type div_pos_ff  [DS+1];
   logic [RW-1:0]         div_dmag_ff [DS+1];
   logic [RW-1:0]         div_rem_ff  [DS+1][3];
   logic [DW-1:0]         div_dvd_ff  [DS+1][3];
   logic [FB-1:0]         div_quo_ff  [DS+1][3];
   logic                  div_neg_ff  [DS+1][3];

   logic [RW-1:0]            div0_dmag_in;
   logic [DW-1:0]            div0_dvd_in [3];
   logic                     div0_neg_in [3];
   logic                     det_neg;
   logic [pcw_pkg::NUM_W-1:0] nmag;

   always_comb begin
      det_neg      = st3_det_ff[pcw_pkg::DET_W-1];
      div0_dmag_in = det_neg ? RW'(-st3_det_ff) : RW'(st3_det_ff);
      nmag         = '0;
      for (int j = 0; j < 3; j++) begin
         nmag = st3_num_ff[j][pcw_pkg::NUM_W-1] ? pcw_pkg::NUM_W'(-st3_num_ff[j])
                                                : pcw_pkg::NUM_W'(st3_num_ff[j]);
         div0_dvd_in[j] = DW'(nmag) << pcw_pkg::WSHIFT;
         div0_neg_in[j] = st3_num_ff[j][pcw_pkg::NUM_W-1] ^ det_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) div_vld_ff[0] <= 1'b0;
      else if (adv) div_vld_ff[0] <= st3_vld_ff;
      if (adv) begin
         div_sing_ff[0] <= (st3_det_ff == '0);
         div_pos_ff[0]  <= st3_pos_ff;
         div_dmag_ff[0] <= div0_dmag_in;
         for (int j = 0; j < 3; j++) begin
            div_rem_ff[0][j] <= '0;
            div_dvd_ff[0][j] <= div0_dvd_in[j];
            div_quo_ff[0][j] <= '0;
            div_neg_ff[0][j] <= div0_neg_in[j];
         end
      end
   end

   for (genvar gs = 1; gs <= DS; gs++) begin : g_div
      logic [RW-1:0] div_rem_in [3];
      logic [DW-1:0] div_dvd_in [3];
      logic [FB-1:0] div_quo_in [3];

      always_comb begin
         for (int j = 0; j < 3; j++) begin
            logic [RW-1:0] r;
            logic [DW-1:0] d;
            logic [FB-1:0] q;
            r = div_rem_ff[gs-1][j];
            d = div_dvd_ff[gs-1][j];
            q = div_quo_ff[gs-1][j];
            for (int t = 0; t < pcw_pkg::DSTEP; t++) begin
               r = {r[RW-2:0], d[DW-1]};
               d = {d[DW-2:0], 1'b0};
               if (r >= div_dmag_ff[gs-1]) begin
                  r = r - div_dmag_ff[gs-1];
                  q = {q[FB-2:0], 1'b1};
               end else begin
                  q = {q[FB-2:0], 1'b0};
               end
            end
            div_rem_in[j] = r;
            div_dvd_in[j] = d;
            div_quo_in[j] = q;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) div_vld_ff[gs] <= 1'b0;
         else if (adv) div_vld_ff[gs] <= div_vld_ff[gs-1];
         if (adv) begin
            div_sing_ff[gs] <= div_sing_ff[gs-1];
            div_pos_ff[gs]  <= div_pos_ff[gs-1];
            div_dmag_ff[gs] <= div_dmag_ff[gs-1];
            for (int j = 0; j < 3; j++) begin
               div_rem_ff[gs][j] <= div_rem_in[j];
               div_dvd_ff[gs][j] <= div_dvd_in[j];
               div_quo_ff[gs][j] <= div_quo_in[j];
               div_neg_ff[gs][j] <= div_neg_ff[gs-1][j];
            end
         end
      end
   end

   // wrap stage: signed floor quotient, then tolerance wrap
   logic                  stg_vld_ff;
   logic                  stg_sing_ff;
   pcw_pkg::req_word_type stg_pos_ff;
   logic signed [GW-1:0]  stg_g_ff [3];
   logic signed [GW-1:0]  stg_g_in [3];
   logic [FB-1:0]         tol_fix;

   assign tol_fix = FB'(tol_ff) << (FB - pcw_pkg::TOL_BITS);

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         logic [FB-1:0] qf;
         logic [FB-1:0] qt;
         qf = div_neg_ff[DS][j] ? (-div_quo_ff[DS][j] - FB'(|div_rem_ff[DS][j]))
                                : div_quo_ff[DS][j];
         qt = qf + tol_fix;
         stg_g_in[j] = signed'({1'b0, qt}) - signed'({1'b0, tol_fix});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) stg_vld_ff <= 1'b0;
      else if (adv) stg_vld_ff <= div_vld_ff[DS];
      if (adv) begin
         stg_sing_ff <= div_sing_ff[DS];
         stg_pos_ff  <= div_pos_ff[DS];
         stg_g_ff    <= stg_g_in;
      end
   end

   // back to cartesian: products
   logic                              stm_vld_ff;
   logic                              stm_sing_ff;
   pcw_pkg::req_word_type             stm_pos_ff;
   logic signed [pcw_pkg::OP_W-1:0]   stm_op_ff [3][3];
   logic signed [pcw_pkg::OP_W-1:0]   stm_op_in [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            stm_op_in[i][k] = v[k][i] * stg_g_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) stm_vld_ff <= 1'b0;
      else if (adv) stm_vld_ff <= stg_vld_ff;
      if (adv) begin
         stm_sing_ff <= stg_sing_ff;
         stm_pos_ff  <= stg_pos_ff;
         stm_op_ff   <= stm_op_in;
      end
   end

   // sums with rounding offset
   logic                  sts_vld_ff;
   logic                  sts_sing_ff;
   pcw_pkg::req_word_type sts_pos_ff;
   logic signed [SW-1:0]  sts_sum_ff [3];
   logic signed [SW-1:0]  sts_sum_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++)
         sts_sum_in[i] = SW'(stm_op_ff[i][0]) + SW'(stm_op_ff[i][1])
                       + SW'(stm_op_ff[i][2]) + (SW'(1) <<< (pcw_pkg::WSHIFT - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) sts_vld_ff <= 1'b0;
      else if (adv) sts_vld_ff <= stm_vld_ff;
      if (adv) begin
         sts_sing_ff <= stm_sing_ff;
         sts_pos_ff  <= stm_pos_ff;
         sts_sum_ff  <= sts_sum_in;
      end
   end

   // shift, saturate, output word
   logic signed [PW-1:0]  sat [3];
   pcw_pkg::rsp_word_type rsp_data_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [SW-1:0] sh;
         sh = sts_sum_ff[i] >>> pcw_pkg::WSHIFT;
         if (sh > (SW'(1) <<< (PW - 1)) - SW'(1))
            sat[i] = {1'b0, {(PW-1){1'b1}}};
         else if (sh < -(SW'(1) <<< (PW - 1)))
            sat[i] = {1'b1, {(PW-1){1'b0}}};
         else
            sat[i] = sh[PW-1:0];
      end
      if (sts_sing_ff) begin
         rsp_data_in.wrapped_x = sts_pos_ff.pos_x;
         rsp_data_in.wrapped_y = sts_pos_ff.pos_y;
         rsp_data_in.wrapped_z = sts_pos_ff.pos_z;
      end else begin
         rsp_data_in.wrapped_x = sat[0];
         rsp_data_in.wrapped_y = sat[1];
         rsp_data_in.wrapped_z = sat[2];
      end
      rsp_data_in.singular_lattice = sts_sing_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= sts_vld_ff;
      if (adv) rsp_data_ff <= rsp_data_in;
   end

   // zero determinant marks the word singular on entry to the divider
   assert property (@(posedge clock) disable iff (reset)
      (st3_vld_ff && adv && st3_det_ff == '0) |=> div_sing_ff[0])
      else $error("singular flag lost at divider entry");

   // long division leaves a remainder below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (div_vld_ff[DS] && !div_sing_ff[DS]) |->
         (div_rem_ff[DS][0] < div_dmag_ff[DS] && div_rem_ff[DS][1] < div_dmag_ff[DS]
          && div_rem_ff[DS][2] < div_dmag_ff[DS]))
      else $error("divider remainder out of range");

   // a stall freezes the pipeline behind the output word
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(sts_vld_ff) && $stable(stg_vld_ff) && $stable(div_vld_ff[0])))
      else $error("pipeline moved during stall");

   // the first wrapped component does not fall below the tolerance band
   assert property (@(posedge clock) disable iff (reset)
      (stg_vld_ff && !stg_sing_ff) |->
         (stg_g_ff[0] >= -signed'({1'b0, tol_fix})))
      else $error("wrapped coordinate below band");

endmodule
